[hw/rtl/sopd_pkg.sv]
`timescale 1ns / 1ps

package sopd_pkg;

    // Operands carried beside each word: the angle and its square
    typedef struct packed {
        logic [63:0] x;
        logic [63:0] z;
    } side_t;

    // Polynomial coefficients, subtracted terms stored negated
    localparam logic [63:0] C9_BITS     = 64'h3EC71DE3A556C734;
    localparam logic [63:0] NEG_C7_BITS = 64'hBF2A01A01A01A01A;
    localparam logic [63:0] C5_BITS     = 64'h3F81111111111111;
    localparam logic [63:0] NEG_C3_BITS = 64'hBFC5555555555555;
    localparam logic [63:0] ONE_BITS    = 64'h3FF0000000000000;

    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8000000000000;
    localparam logic [63:0] QUIET_MASK  = 64'h0008000000000000;
    localparam logic [10:0] EXP_MAX     = 11'h7FF;

    function automatic logic is_nan(input logic [63:0] v);
        return (v[62:52] == EXP_MAX) && (v[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input logic [63:0] v);
        return (v[62:52] == EXP_MAX) && (v[51:0] == 52'd0);
    endfunction

    // Leading zeros of a 106-bit product, 106 for a zero input
    function automatic logic [6:0] lzc106(input logic [105:0] v);
        logic [6:0] n;
        n = 7'd106;
        for (int i = 0; i < 106; i++)
        begin
            if (v[i])
            begin
                n = 7'(105 - i);
            end
        end
        return n;
    endfunction

    // Leading zeros of a 57-bit sum
    function automatic logic [5:0] lzc57(input logic [56:0] v);
        logic [5:0] n;
        n = 6'd57;
        for (int i = 0; i < 57; i++)
        begin
            if (v[i])
            begin
                n = 6'(56 - i);
            end
        end
        return n;
    endfunction

endpackage

[hw/rtl/sopd_fmul.sv]
`timescale 1ns / 1ps

// Five-stage binary64 multiplier, round to nearest even
module sopd_fmul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [63:0]          a,
    input  logic [63:0]          b,
    input  sopd_pkg::side_t      in_side,
    output logic                 out_vld,
    output logic [63:0]          y,
    output sopd_pkg::side_t      out_side
);

    // ---------------- stage 1: unpack, partial products ----------------
    logic [10:0]  ea, eb;
    logic [52:0]  ma, mb;
    logic [11:0]  esum_next;
    logic         spec_next;
    logic [63:0]  spec_val_next;
    logic [51:0]  pp_hh_next;
    logic [52:0]  pp_hl_next, pp_lh_next;
    logic [53:0]  pp_ll_next;

    always_comb
    begin
        ea = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
        eb = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
        ma = {(a[62:52] != 11'd0), a[51:0]};
        mb = {(b[62:52] != 11'd0), b[51:0]};
        esum_next = {1'b0, ea} + {1'b0, eb};
        pp_hh_next = 52'(ma[52:27] * mb[52:27]);
        pp_hl_next = 53'(ma[52:27] * mb[26:0]);
        pp_lh_next = 53'(ma[26:0] * mb[52:27]);
        pp_ll_next = 54'(ma[26:0] * mb[26:0]);
        spec_next = sopd_pkg::is_nan(a) || sopd_pkg::is_nan(b)
                    || sopd_pkg::is_inf(a) || sopd_pkg::is_inf(b);
        priority if (sopd_pkg::is_nan(a))
            spec_val_next = a | sopd_pkg::QUIET_MASK;
        else if (sopd_pkg::is_nan(b))
            spec_val_next = b | sopd_pkg::QUIET_MASK;
        else if ((sopd_pkg::is_inf(a) && b[62:0] == 63'd0)
                 || (sopd_pkg::is_inf(b) && a[62:0] == 63'd0))
            spec_val_next = sopd_pkg::DEFAULT_NAN;
        else
            spec_val_next = {a[63] ^ b[63], sopd_pkg::EXP_MAX, 52'd0};
    end

    logic                 s1_vld_reg;
    logic                 s1_sign_reg;
    logic                 s1_spec_reg;
    logic [63:0]          s1_spec_val_reg;
    logic [11:0]          s1_esum_reg;
    logic [51:0]          s1_hh_reg;
    logic [52:0]          s1_hl_reg, s1_lh_reg;
    logic [53:0]          s1_ll_reg;
    sopd_pkg::side_t      s1_side_reg;

    // ---------------- stage 2: sum partial products ----------------
    logic [105:0] prod_next;

    always_comb
    begin
        prod_next = ({54'd0, s1_hh_reg} << 54)
                    + (({53'd0, s1_hl_reg} + {53'd0, s1_lh_reg}) << 27)
                    + {52'd0, s1_ll_reg};
    end

    logic                 s2_vld_reg;
    logic                 s2_sign_reg;
    logic                 s2_spec_reg;
    logic [63:0]          s2_spec_val_reg;
    logic [11:0]          s2_esum_reg;
    logic [105:0]         s2_prod_reg;
    sopd_pkg::side_t      s2_side_reg;

    // ---------------- stage 3: leading zeros, exponent ----------------
    logic [6:0]          lz;
    logic signed [13:0]  er_next;
    logic signed [13:0]  sh_next;

    always_comb
    begin
        lz = sopd_pkg::lzc106(s2_prod_reg);
        er_next = $signed({2'b00, s2_esum_reg}) - $signed({7'd0, lz}) - 14'sd1022;
        if (er_next >= 14'sd1)
            sh_next = $signed({7'd0, lz});
        else
            sh_next = $signed({7'd0, lz}) + er_next - 14'sd1;
    end

    logic                 s3_vld_reg;
    logic                 s3_sign_reg;
    logic                 s3_spec_reg;
    logic [63:0]          s3_spec_val_reg;
    logic                 s3_zero_reg;
    logic signed [13:0]   s3_er_reg;
    logic signed [13:0]   s3_sh_reg;
    logic [105:0]         s3_prod_reg;
    sopd_pkg::side_t      s3_side_reg;

    // ---------------- stage 4: normalize or denormalize ----------------
    logic signed [13:0] rsh;
    logic [6:0]         rs7;
    logic [105:0]       q_next;
    logic               stk_next;

    always_comb
    begin
        rsh = -s3_sh_reg;
        rs7 = (rsh > 14'sd127) ? 7'd127 : rsh[6:0];
        if (s3_sh_reg >= 14'sd0)
        begin
            q_next = s3_prod_reg << s3_sh_reg[6:0];
            stk_next = 1'b0;
        end
        else
        begin
            q_next = s3_prod_reg >> rs7;
            stk_next = |(s3_prod_reg & ~({106{1'b1}} << rs7));
        end
    end

    logic                 s4_vld_reg;
    logic                 s4_sign_reg;
    logic                 s4_spec_reg;
    logic [63:0]          s4_spec_val_reg;
    logic                 s4_zero_reg;
    logic signed [13:0]   s4_er_reg;
    logic [105:0]         s4_q_reg;
    logic                 s4_stk_reg;
    sopd_pkg::side_t      s4_side_reg;

    // ---------------- stage 5: round and pack ----------------
    logic        inc;
    logic [10:0] efield;
    logic [62:0] rounded;
    logic [63:0] y_next;

    always_comb
    begin
        inc = s4_q_reg[52] & ((|s4_q_reg[51:0]) | s4_stk_reg | s4_q_reg[53]);
        efield = (s4_er_reg >= 14'sd1) ? s4_er_reg[10:0] : 11'd0;
        rounded = {efield, s4_q_reg[104:53]} + {62'd0, inc};
        priority if (s4_spec_reg)
            y_next = s4_spec_val_reg;
        else if (s4_zero_reg)
            y_next = {s4_sign_reg, 63'd0};
        else if (s4_er_reg >= 14'sd2047)
            y_next = {s4_sign_reg, sopd_pkg::EXP_MAX, 52'd0};
        else
            y_next = {s4_sign_reg, rounded};
    end

    logic                 s5_vld_reg;
    logic [63:0]          s5_y_reg;
    sopd_pkg::side_t      s5_side_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sign_reg     <= a[63] ^ b[63];
            s1_spec_reg     <= spec_next;
            s1_spec_val_reg <= spec_val_next;
            s1_esum_reg     <= esum_next;
            s1_hh_reg       <= pp_hh_next;
            s1_hl_reg       <= pp_hl_next;
            s1_lh_reg       <= pp_lh_next;
            s1_ll_reg       <= pp_ll_next;
            s1_side_reg     <= in_side;

            s2_sign_reg     <= s1_sign_reg;
            s2_spec_reg     <= s1_spec_reg;
            s2_spec_val_reg <= s1_spec_val_reg;
            s2_esum_reg     <= s1_esum_reg;
            s2_prod_reg     <= prod_next;
            s2_side_reg     <= s1_side_reg;

            s3_sign_reg     <= s2_sign_reg;
            s3_spec_reg     <= s2_spec_reg;
            s3_spec_val_reg <= s2_spec_val_reg;
            s3_zero_reg     <= (s2_prod_reg == 106'd0);
            s3_er_reg       <= er_next;
            s3_sh_reg       <= sh_next;
            s3_prod_reg     <= s2_prod_reg;
            s3_side_reg     <= s2_side_reg;

            s4_sign_reg     <= s3_sign_reg;
            s4_spec_reg     <= s3_spec_reg;
            s4_spec_val_reg <= s3_spec_val_reg;
            s4_zero_reg     <= s3_zero_reg;
            s4_er_reg       <= s3_er_reg;
            s4_q_reg        <= q_next;
            s4_stk_reg      <= stk_next;
            s4_side_reg     <= s3_side_reg;

            s5_y_reg        <= y_next;
            s5_side_reg     <= s4_side_reg;
        end
    end

    assign out_vld  = s5_vld_reg;
    assign y        = s5_y_reg;
    assign out_side = s5_side_reg;

endmodule

[hw/rtl/sopd_fadd.sv]
`timescale 1ns / 1ps

// Five-stage binary64 adder, round to nearest even
module sopd_fadd (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [63:0]          a,
    input  logic [63:0]          b,
    input  sopd_pkg::side_t      in_side,
    output logic                 out_vld,
    output logic [63:0]          y,
    output sopd_pkg::side_t      out_side
);

    // ---------------- stage 1: unpack, order by magnitude ----------------
    logic         swap;
    logic [63:0]  big, sml;
    logic [10:0]  eb_eff, es_eff;
    logic [10:0]  d_next;
    logic         spec_next;
    logic [63:0]  spec_val_next;

    always_comb
    begin
        swap = (b[62:0] > a[62:0]);
        big = swap ? b : a;
        sml = swap ? a : b;
        eb_eff = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
        es_eff = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
        d_next = eb_eff - es_eff;
        spec_next = sopd_pkg::is_nan(a) || sopd_pkg::is_nan(b)
                    || sopd_pkg::is_inf(a) || sopd_pkg::is_inf(b);
        priority if (sopd_pkg::is_nan(a))
            spec_val_next = a | sopd_pkg::QUIET_MASK;
        else if (sopd_pkg::is_nan(b))
            spec_val_next = b | sopd_pkg::QUIET_MASK;
        else if (sopd_pkg::is_inf(a) && sopd_pkg::is_inf(b) && (a[63] != b[63]))
            spec_val_next = sopd_pkg::DEFAULT_NAN;
        else if (sopd_pkg::is_inf(a))
            spec_val_next = a;
        else
            spec_val_next = b;
    end

    logic                 s1_vld_reg;
    logic                 s1_sign_reg;
    logic                 s1_sub_reg;
    logic                 s1_zsign_reg;
    logic                 s1_spec_reg;
    logic [63:0]          s1_spec_val_reg;
    logic [10:0]          s1_e_reg;
    logic [10:0]          s1_d_reg;
    logic [52:0]          s1_mb_reg, s1_ms_reg;
    sopd_pkg::side_t      s1_side_reg;

    // ---------------- stage 2: align smaller operand ----------------
    logic [5:0]  dd;
    logic [55:0] ms_ext;
    logic [55:0] ms_al_next;

    always_comb
    begin
        dd = (s1_d_reg > 11'd63) ? 6'd63 : s1_d_reg[5:0];
        ms_ext = {s1_ms_reg, 3'b000};
        ms_al_next = (ms_ext >> dd)
                     | {55'd0, |(ms_ext & ~({56{1'b1}} << dd))};
    end

    logic                 s2_vld_reg;
    logic                 s2_sign_reg;
    logic                 s2_sub_reg;
    logic                 s2_zsign_reg;
    logic                 s2_spec_reg;
    logic [63:0]          s2_spec_val_reg;
    logic [10:0]          s2_e_reg;
    logic [55:0]          s2_mb_reg, s2_ms_reg;
    sopd_pkg::side_t      s2_side_reg;

    // ---------------- stage 3: add or subtract magnitudes ----------------
    logic [56:0] sum_next;

    always_comb
    begin
        if (s2_sub_reg)
            sum_next = {1'b0, s2_mb_reg} - {1'b0, s2_ms_reg};
        else
            sum_next = {1'b0, s2_mb_reg} + {1'b0, s2_ms_reg};
    end

    logic                 s3_vld_reg;
    logic                 s3_sign_reg;
    logic                 s3_zsign_reg;
    logic                 s3_spec_reg;
    logic [63:0]          s3_spec_val_reg;
    logic [10:0]          s3_e_reg;
    logic [56:0]          s3_sum_reg;
    sopd_pkg::side_t      s3_side_reg;

    // ---------------- stage 4: leading zeros, shift amount ----------------
    logic [5:0]  lz;
    logic [5:0]  lz55;
    logic [10:0] emax_sh;
    logic [5:0]  sh_next;
    logic [11:0] e_new_next;

    always_comb
    begin
        lz = sopd_pkg::lzc57(s3_sum_reg);
        lz55 = (lz == 6'd0) ? 6'd0 : lz - 6'd1;
        emax_sh = s3_e_reg - 11'd1;
        sh_next = ({5'd0, lz55} > emax_sh) ? emax_sh[5:0] : lz55;
        if (s3_sum_reg[56])
            e_new_next = {1'b0, s3_e_reg} + 12'd1;
        else
            e_new_next = {1'b0, s3_e_reg} - {6'd0, sh_next};
    end

    logic                 s4_vld_reg;
    logic                 s4_sign_reg;
    logic                 s4_zsign_reg;
    logic                 s4_spec_reg;
    logic [63:0]          s4_spec_val_reg;
    logic                 s4_zero_reg;
    logic [5:0]           s4_sh_reg;
    logic [11:0]          s4_e_reg;
    logic [56:0]          s4_sum_reg;
    sopd_pkg::side_t      s4_side_reg;

    // ---------------- stage 5: normalize, round, pack ----------------
    logic [55:0] xn;
    logic        inc;
    logic [10:0] efield;
    logic [62:0] rounded;
    logic [63:0] y_next;

    always_comb
    begin
        if (s4_sum_reg[56])
            xn = s4_sum_reg[56:1] | {55'd0, s4_sum_reg[0]};
        else
            xn = s4_sum_reg[55:0] << s4_sh_reg;
        inc = xn[2] & (xn[1] | xn[0] | xn[3]);
        efield = xn[55] ? s4_e_reg[10:0] : 11'd0;
        rounded = {efield, xn[54:3]} + {62'd0, inc};
        priority if (s4_spec_reg)
            y_next = s4_spec_val_reg;
        else if (s4_zero_reg)
            y_next = {s4_zsign_reg, 63'd0};
        else if (s4_e_reg >= 12'd2047)
            y_next = {s4_sign_reg, sopd_pkg::EXP_MAX, 52'd0};
        else
            y_next = {s4_sign_reg, rounded};
    end

    logic                 s5_vld_reg;
    logic [63:0]          s5_y_reg;
    sopd_pkg::side_t      s5_side_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sign_reg     <= big[63];
            s1_sub_reg      <= a[63] ^ b[63];
            s1_zsign_reg    <= a[63] & b[63];
            s1_spec_reg     <= spec_next;
            s1_spec_val_reg <= spec_val_next;
            s1_e_reg        <= eb_eff;
            s1_d_reg        <= d_next;
            s1_mb_reg       <= {(big[62:52] != 11'd0), big[51:0]};
            s1_ms_reg       <= {(sml[62:52] != 11'd0), sml[51:0]};
            s1_side_reg     <= in_side;

            s2_sign_reg     <= s1_sign_reg;
            s2_sub_reg      <= s1_sub_reg;
            s2_zsign_reg    <= s1_zsign_reg;
            s2_spec_reg     <= s1_spec_reg;
            s2_spec_val_reg <= s1_spec_val_reg;
            s2_e_reg        <= s1_e_reg;
            s2_mb_reg       <= {s1_mb_reg, 3'b000};
            s2_ms_reg       <= ms_al_next;
            s2_side_reg     <= s1_side_reg;

            s3_sign_reg     <= s2_sign_reg;
            s3_zsign_reg    <= s2_zsign_reg;
            s3_spec_reg     <= s2_spec_reg;
            s3_spec_val_reg <= s2_spec_val_reg;
            s3_e_reg        <= s2_e_reg;
            s3_sum_reg      <= sum_next;
            s3_side_reg     <= s2_side_reg;

            s4_sign_reg     <= s3_sign_reg;
            s4_zsign_reg    <= s3_zsign_reg;
            s4_spec_reg     <= s3_spec_reg;
            s4_spec_val_reg <= s3_spec_val_reg;
            s4_zero_reg     <= (s3_sum_reg == 57'd0);
            s4_sh_reg       <= sh_next;
            s4_e_reg        <= e_new_next;
            s4_sum_reg      <= s3_sum_reg;
            s4_side_reg     <= s3_side_reg;

            s5_y_reg        <= y_next;
            s5_side_reg     <= s4_side_reg;
        end
    end

    assign out_vld  = s5_vld_reg;
    assign y        = s5_y_reg;
    assign out_side = s5_side_reg;

endmodule

[hw/rtl/sine_odd_polynomial_double_unit.sv]
// Ten chained binary64 operations, five register stages each, lie between
// the angle word accepted and the sine word valid.
// Throughput: one word per cycle; the whole pipe holds while the output
// word waits to be taken.
// Reset: rst_n asynchronous, active low, clears all valid bits.
`timescale 1ns / 1ps

module sine_odd_polynomial_double_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        angle_valid,
    output logic        angle_ready,
    input  logic [63:0] angle_bits,
    output logic        sine_valid,
    input  logic        sine_ready,
    output logic [63:0] sine_bits
);

    // Pipe advances unless the output word is stuck
    logic en;
    assign en = !sine_valid || sine_ready;
    assign angle_ready = en;

    logic                v0, v1, v2, v3, v4, v5, v6, v7, v8, v9;
    logic [63:0]         r0, r1, r2, r3, r4, r5, r6, r7, r8;
    sopd_pkg::side_t     sd_in, sd0, sd1, sd2, sd3, sd4, sd5, sd6, sd7, sd8;
    sopd_pkg::side_t     sd0z;

    assign sd_in = '{x: angle_bits, z: 64'd0};
    assign sd0z  = '{x: sd0.x, z: r0};

    // z = x * x
    sopd_fmul u_mul_z (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(angle_valid),
        .a(angle_bits), .b(angle_bits), .in_side(sd_in),
        .out_vld(v0), .y(r0), .out_side(sd0)
    );

    // t = c9 * z
    sopd_fmul u_mul_c9 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v0),
        .a(sopd_pkg::C9_BITS), .b(r0), .in_side(sd0z),
        .out_vld(v1), .y(r1), .out_side(sd1)
    );

    // t = t - c7
    sopd_fadd u_add_c7 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v1),
        .a(r1), .b(sopd_pkg::NEG_C7_BITS), .in_side(sd1),
        .out_vld(v2), .y(r2), .out_side(sd2)
    );

    sopd_fmul u_mul_2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v2),
        .a(r2), .b(sd2.z), .in_side(sd2),
        .out_vld(v3), .y(r3), .out_side(sd3)
    );

    // t = t + c5
    sopd_fadd u_add_c5 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v3),
        .a(r3), .b(sopd_pkg::C5_BITS), .in_side(sd3),
        .out_vld(v4), .y(r4), .out_side(sd4)
    );

    sopd_fmul u_mul_3 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v4),
        .a(r4), .b(sd4.z), .in_side(sd4),
        .out_vld(v5), .y(r5), .out_side(sd5)
    );

    // t = t - c3
    sopd_fadd u_add_c3 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v5),
        .a(r5), .b(sopd_pkg::NEG_C3_BITS), .in_side(sd5),
        .out_vld(v6), .y(r6), .out_side(sd6)
    );

    sopd_fmul u_mul_4 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v6),
        .a(r6), .b(sd6.z), .in_side(sd6),
        .out_vld(v7), .y(r7), .out_side(sd7)
    );

    // t = t + 1
    sopd_fadd u_add_one (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v7),
        .a(r7), .b(sopd_pkg::ONE_BITS), .in_side(sd7),
        .out_vld(v8), .y(r8), .out_side(sd8)
    );

    // result = x * t, last stage doubles as the output register
    sopd_fmul u_mul_x (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v8),
        .a(sd8.x), .b(r8), .in_side(sd8),
        .out_vld(v9), .y(sine_bits), .out_side()
    );

    assign sine_valid = v9;

endmodule
